>>> rtl/core/scab_pkg.sv
// scab_pkg: shared types, codes and decode functions for the size-class block allocator
// no dependencies; used by scab_ctrl, scab_dp and size_class_block_allocator
package scab_pkg;

  // geometry
  localparam int unsigned NUM_CLASSES      = 8;
  localparam int unsigned CLASS_W          = 3;
  localparam int unsigned INDEX_W          = 6;
  localparam int unsigned SIZE_W           = 8;
  localparam int unsigned BYTES_W          = 7;
  localparam int unsigned BLOCKS_PER_CLASS = 64;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, decode it, launch the stack read
    logic commit;   // apply the stack update and load the result register
  } scab_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_full;  // result register holds an untaken result
  } scab_sts_t;

  // size decode result
  typedef struct packed {
    logic               ok;
    logic [CLASS_W-1:0] cls;
  } class_dec_t;

  // map a request size to its class
  function automatic class_dec_t size_to_class(input logic [SIZE_W-1:0] size);
    class_dec_t d;
    d.ok  = 1'b1;
    d.cls = '0;
    case (size) inside
      [8'd1:8'd4]:   d.cls = 3'd0;
      [8'd5:8'd12]:  d.cls = 3'd1;
      [8'd13:8'd20]: d.cls = 3'd2;
      [8'd21:8'd28]: d.cls = 3'd3;
      [8'd29:8'd36]: d.cls = 3'd4;
      [8'd37:8'd44]: d.cls = 3'd5;
      8'd56:         d.cls = 3'd6;
      8'd64:         d.cls = 3'd7;
      default:       d.ok  = 1'b0;
    endcase
    return d;
  endfunction

  // block size of each class
  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
    logic [BYTES_W-1:0] b;
    unique case (cls)
      3'd0:    b = 7'd8;
      3'd1:    b = 7'd16;
      3'd2:    b = 7'd24;
      3'd3:    b = 7'd32;
      3'd4:    b = 7'd40;
      3'd5:    b = 7'd48;
      3'd6:    b = 7'd60;
      default: b = 7'd68;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/size_class_block_allocator.sv
// size_class_block_allocator: eight LIFO free stacks of block indices, alloc/free requests
// request registered at capture, result at commit; no new request is taken before commit
// the single-port stack memory is read in the accept cycle and pushed in the commit cycle
// a new request is taken while an earlier result still waits in the output register
// reset is synchronous; no clearing pass: per-class low-water marks stand in for the
// reset content of the stacks, so requests are taken from the first cycle after reset
module size_class_block_allocator #(
  parameter int unsigned BLOCKS_PER_CLASS = scab_pkg::BLOCKS_PER_CLASS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [scab_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [scab_pkg::CLASS_W-1:0]  in_free_class,
  input  logic [scab_pkg::INDEX_W-1:0]  in_free_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [scab_pkg::CLASS_W-1:0]  out_block_class,
  output logic [scab_pkg::INDEX_W-1:0]  out_block_index,
  output logic [scab_pkg::BYTES_W-1:0]  out_block_bytes
);

  scab_pkg::scab_cmd_t cmd;
  scab_pkg::scab_sts_t sts;

  // sequencer
  scab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stacks, counts and result register
  scab_dp #(
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_request_size (in_request_size),
    .in_free_class   (in_free_class),
    .in_free_index   (in_free_index),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_class (out_block_class),
    .out_block_index (out_block_index),
    .out_block_bytes (out_block_bytes)
  );

endmodule

>>> rtl/core/scab_ctrl.sv
// scab_ctrl: two-state sequencer for the size-class block allocator
// depends on scab_pkg for command and status structs
module scab_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  scab_pkg::scab_sts_t  sts,
  output scab_pkg::scab_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // handshake and commands
  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state_r == S_EXEC) && (!sts.out_full || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_EXEC;
      S_EXEC: if (cmd.commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a captured request always goes to execute
  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_EXEC))
    else $error("capture did not enter execute");

  // commit frees the input side on the next cycle
  a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_ready)
    else $error("commit did not return to idle");

  // no commit without a captured request
  a_commit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !in_ready)
    else $error("commit while idle");

endmodule

>>> rtl/core/scab_dp.sv
// scab_dp: free-stack memory, per-class counts and low-water marks, result register
// depends on scab_pkg for codes, decode functions and command/status structs
module scab_dp #(
  parameter int unsigned BLOCKS_PER_CLASS = scab_pkg::BLOCKS_PER_CLASS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  scab_pkg::scab_cmd_t                   cmd,
  output scab_pkg::scab_sts_t                   sts,
  input  logic                                  in_opcode,
  input  logic [scab_pkg::SIZE_W-1:0]           in_request_size,
  input  logic [scab_pkg::CLASS_W-1:0]          in_free_class,
  input  logic [scab_pkg::INDEX_W-1:0]          in_free_index,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [scab_pkg::CLASS_W-1:0]          out_block_class,
  output logic [scab_pkg::INDEX_W-1:0]          out_block_index,
  output logic [scab_pkg::BYTES_W-1:0]          out_block_bytes
);

  localparam int unsigned PW    = $clog2(BLOCKS_PER_CLASS);
  localparam int unsigned CW    = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int unsigned AW    = scab_pkg::CLASS_W + PW;
  localparam int unsigned DEPTH = scab_pkg::NUM_CLASSES << PW;
  localparam int unsigned IW    = scab_pkg::INDEX_W;
  localparam logic [CW-1:0] FULL = CW'(BLOCKS_PER_CLASS);

  // per-class state: count and lowest count ever reached
  logic [CW-1:0] count_r [scab_pkg::NUM_CLASSES];
  logic [CW-1:0] lowm_r  [scab_pkg::NUM_CLASSES];

  // stacked indices, one region per class
  logic [IW-1:0] mem_r [DEPTH];
  logic [IW-1:0] rd_data_r;

  // captured request
  scab_pkg::status_t              st_r;
  logic [scab_pkg::CLASS_W-1:0]   cls_r;
  logic [IW-1:0]                  fidx_r;
  logic [CW-1:0]                  pos_r;
  logic                           pop_r;
  logic                           push_r;
  logic                           use_reset_r;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  scab_pkg::status_t              out_status_r;
  logic [scab_pkg::CLASS_W-1:0]   out_class_r;
  logic [IW-1:0]                  out_index_r;
  logic [scab_pkg::BYTES_W-1:0]   out_bytes_r;

  // request decode
  scab_pkg::class_dec_t           dec;
  logic                           is_free;
  logic [scab_pkg::CLASS_W-1:0]   in_cls;
  logic [CW-1:0]                  cnt;
  logic [CW-1:0]                  lw;
  scab_pkg::status_t              st_c;
  logic [scab_pkg::CLASS_W-1:0]   res_cls_c;
  logic [CW-1:0]                  pos_c;
  logic                           pop_c;
  logic                           push_c;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic [CW+IW-1:0]               pos_wide;
  logic [IW-1:0]                  idx_c;

  assign dec     = scab_pkg::size_to_class(in_request_size);
  assign is_free = (in_opcode == scab_pkg::OP_FREE);
  assign in_cls  = is_free ? in_free_class : dec.cls;
  assign cnt     = count_r[in_cls];
  assign lw      = lowm_r[in_cls];

  always_comb begin
    st_c      = scab_pkg::ST_OK;
    res_cls_c = in_cls;
    pos_c     = cnt;
    pop_c     = 1'b0;
    push_c    = 1'b0;
    if (is_free) begin
      if (cnt == FULL) begin
        st_c = scab_pkg::ST_OVERFLOW;
      end else begin
        push_c = 1'b1;
      end
    end else if (!dec.ok) begin
      st_c      = scab_pkg::ST_BAD_SIZE;
      res_cls_c = '0;
    end else if (cnt == '0) begin
      st_c = scab_pkg::ST_EXHAUSTED;
    end else begin
      pop_c = 1'b1;
      pos_c = cnt - CW'(1);
    end
  end

  assign rd_addr = {in_cls, pos_c[PW-1:0]};
  assign wr_addr = {cls_r, pos_r[PW-1:0]};

  // capture the decoded request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_r        <= st_c;
      fidx_r      <= in_free_index;
      pos_r       <= pos_c;
      use_reset_r <= (pos_c < lw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r  <= '0;
      pop_r  <= 1'b0;
      push_r <= 1'b0;
    end else if (cmd.capture) begin
      cls_r  <= res_cls_c;
      pop_r  <= pop_c;
      push_r <= push_c;
    end
  end

  // stack memory: read at capture, push written at commit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && push_r) begin
      mem_r[wr_addr] <= fidx_r;
    end
  end

  // counts and low-water marks; slots below the mark still hold their reset index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < scab_pkg::NUM_CLASSES; c++) begin
        count_r[c] <= FULL;
        lowm_r[c]  <= FULL;
      end
    end else if (cmd.commit) begin
      if (pop_r) begin
        count_r[cls_r] <= pos_r;
        if (use_reset_r) begin
          lowm_r[cls_r] <= pos_r;
        end
      end else if (push_r) begin
        count_r[cls_r] <= pos_r + CW'(1);
      end
    end
  end

  // granted or freed index
  assign pos_wide = {{IW{1'b0}}, pos_r};

  always_comb begin
    case (st_r)
      scab_pkg::ST_OK: begin
        if (pop_r) begin
          idx_c = use_reset_r ? pos_wide[IW-1:0] : rd_data_r;
        end else begin
          idx_c = fidx_r;
        end
      end
      scab_pkg::ST_OVERFLOW: idx_c = fidx_r;
      default:               idx_c = '0;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= st_r;
      out_class_r  <= cls_r;
      out_index_r  <= idx_c;
      out_bytes_r  <= (st_r == scab_pkg::ST_OK) ? scab_pkg::class_bytes(cls_r) : '0;
    end
  end

  assign sts.out_full     = out_valid_r;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_class  = out_class_r;
  assign out_block_index  = out_index_r;
  assign out_block_bytes  = out_bytes_r;

  // a commit always leaves a result in the register
  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not load result");

  // class count never exceeds the pool size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[cls_r] <= FULL)
    else $error("class count above pool size");

  // low-water mark never above the current count
  a_lowm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lowm_r[cls_r] <= count_r[cls_r])
    else $error("low-water mark above count");

endmodule
